// ===== rtl/r565y420_pkg.sv =====
// constants, types and value functions shared by the rgb565 pair to yuv420 converter
// no dependencies; used by the channel interfaces, the top level and its checker
`default_nettype none

package r565y420_pkg;

  // payload widths
  localparam int unsigned PIXEL_W = 16;
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned COMP_W  = 5;

  // luma index: ((794*b + 2086*r) >> 9) + green8 with low bits cleared, at most 426
  localparam int unsigned LUMA_IDX_W     = 9;
  localparam int unsigned LUMA_MIX_W     = 17;
  localparam int unsigned LUMA_MIX_SHIFT = 9;
  localparam int unsigned LUMA_RED_GAIN  = 2086;
  localparam int unsigned LUMA_BLUE_GAIN = 794;
  localparam int unsigned LUMA_LO        = 16;
  localparam int unsigned LUMA_HI        = 235;

  // chroma index arithmetic
  localparam int unsigned CHROMA_W       = 30;
  localparam int unsigned CHROMA_SHIFT   = 18;
  localparam int unsigned CHROMA_G_SHIFT = 16;
  localparam int          CB_CROSS_GAIN  = 33383;
  localparam int          CR_CROSS_GAIN  = 12698;
  localparam int unsigned DIFF_IDX_W     = 10;
  localparam int          DIFF_OFFSET    = 384;
  localparam int unsigned DIFF_MAX       = 255;

  // luma curve: floor(i * LUMA_NUM / LUMA_DEN + 16.5) as a fixed-point product.
  // the exact value never lies within 1/(2*798125409) of an integer, and the
  // truncated gain errs by less than 426 / 2^40, so the floor is exact
  localparam logic [127:0] LUMA_NUM  = 128'd3220728000;
  localparam logic [127:0] LUMA_DEN  = 128'd6385003272;
  localparam int unsigned  LUMA_FRAC = 40;
  localparam int unsigned  LUMA_PROD_W = LUMA_IDX_W + LUMA_FRAC + 1;
  localparam logic [LUMA_FRAC-1:0] LUMA_GAIN =
    LUMA_FRAC'((LUMA_NUM << LUMA_FRAC) / LUMA_DEN);
  localparam logic [LUMA_PROD_W-1:0] LUMA_BIAS = LUMA_PROD_W'(33) << (LUMA_FRAC - 1);

  // chroma curves: floor(j * num / 5485398 + 128.5), limited to 0..255.
  // the exact value never lies within 1/5485398 of an integer, and the
  // gain error stays below 384 / 2^34
  localparam logic [127:0] DIFF_DEN  = 128'd5485398;
  localparam logic [127:0] CB_NUM    = 128'd1596000;
  localparam logic [127:0] CR_NUM    = 128'd2018000;
  localparam int unsigned  DIFF_FRAC = 34;
  localparam int unsigned  DIFF_PROD_W = DIFF_IDX_W + DIFF_FRAC + 2;
  localparam int unsigned  DIFF_WHOLE_W = DIFF_PROD_W - DIFF_FRAC;
  localparam logic [DIFF_FRAC-1:0] CB_GAIN =
    DIFF_FRAC'((CB_NUM << DIFF_FRAC) / DIFF_DEN);
  localparam logic [DIFF_FRAC-1:0] CR_GAIN =
    DIFF_FRAC'((CR_NUM << DIFF_FRAC) / DIFF_DEN);
  localparam logic signed [DIFF_PROD_W-1:0] DIFF_BIAS =
    DIFF_PROD_W'(257) <<< (DIFF_FRAC - 1);

  typedef logic [CHAN_W-1:0]            chan_t;
  typedef logic [LUMA_IDX_W-1:0]        luma_idx_t;
  typedef logic signed [DIFF_IDX_W-1:0] diff_idx_t;

  // luma table entry for one index
  function automatic chan_t luma_value(input luma_idx_t idx);
    logic [LUMA_PROD_W-1:0]         prod;
    logic [LUMA_PROD_W-LUMA_FRAC-1:0] whole;
    prod  = LUMA_PROD_W'(idx) * LUMA_PROD_W'(LUMA_GAIN) + LUMA_BIAS;
    whole = prod[LUMA_PROD_W-1:LUMA_FRAC];
    if (whole > (LUMA_PROD_W-LUMA_FRAC)'(LUMA_HI)) begin
      return CHAN_W'(LUMA_HI);
    end
    return whole[CHAN_W-1:0];
  endfunction

  // chroma table entry for one signed index, gain selects cb or cr
  function automatic chan_t diff_value(input diff_idx_t idx, input logic [DIFF_FRAC-1:0] gain);
    logic signed [DIFF_PROD_W-1:0]  ix;
    logic signed [DIFF_PROD_W-1:0]  gx;
    logic signed [DIFF_PROD_W-1:0]  prod;
    logic signed [DIFF_WHOLE_W-1:0] whole;
    ix    = DIFF_PROD_W'(idx);
    gx    = $signed({{(DIFF_PROD_W-DIFF_FRAC){1'b0}}, gain});
    prod  = ix * gx + DIFF_BIAS;
    whole = DIFF_WHOLE_W'(prod >>> DIFF_FRAC);
    if (whole < 0) begin
      return '0;
    end
    if (whole > $signed(DIFF_WHOLE_W'(DIFF_MAX))) begin
      return CHAN_W'(DIFF_MAX);
    end
    return whole[CHAN_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/r565y420_pair_if.sv =====
// input channel: a pair of rgb565 pixels and the even row flag
// depends on r565y420_pkg for payload widths
`default_nettype none

interface r565y420_pair_if;
  logic                                valid;
  logic                                ready;
  logic [r565y420_pkg::PIXEL_W-1:0]    pixel_first;
  logic [r565y420_pkg::PIXEL_W-1:0]    pixel_second;
  logic                                even_row;

  modport source (output valid, output pixel_first, output pixel_second, output even_row,
                  input ready);
  modport sink   (input valid, input pixel_first, input pixel_second, input even_row,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/r565y420_yuv_if.sv =====
// result channel: two luma values, one shared cb/cr pair and the keep flag
// depends on r565y420_pkg for payload widths
`default_nettype none

interface r565y420_yuv_if;
  logic                    valid;
  logic                    ready;
  r565y420_pkg::chan_t     luma_first;
  logic [7:0]              luma_second;
  r565y420_pkg::chan_t     chroma_blue;
  r565y420_pkg::chan_t     chroma_red;
  logic                    chroma_keep;

  modport source (output valid, output luma_first, output luma_second, output chroma_blue,
                  output chroma_red, output chroma_keep, input ready);
  modport sink   (input valid, input luma_first, input luma_second, input chroma_blue,
                  input chroma_red, input chroma_keep, output ready);
endinterface

`default_nettype wire

// ===== rtl/rgb565_pair_to_yuv420.sv =====
// rgb565 pixel pair to yuv 4:2:0 converter, two-stage pipeline
// depends on r565y420_pkg, r565y420_pair_if and r565y420_yuv_if
//
//   channel   dir  handshake        payload
//   in_pair   in   valid / ready    pixel_first, pixel_second, even_row
//   out_yuv   out  valid / ready    luma_first, luma_second, chroma_blue, chroma_red,
//                                   chroma_keep
//
// one request per clock while the output register is not stalled
// stage one registers the table indices, stage two registers the looked-up values
// the curve products (luma and chroma gains) set the stage two path
// a stalled result holds in the output register while an empty stage one still takes a request
// synchronous active-low reset empties both stages; ready is low during reset
`default_nettype none

module rgb565_pair_to_yuv420 #(
  parameter int unsigned LUMA_ROM_DEPTH = 575
) (
  input  wire                   clk,
  input  wire                   rst_n,
  r565y420_pair_if.sink         in_pair,
  r565y420_yuv_if.source        out_yuv
);

  localparam int unsigned IW = r565y420_pkg::LUMA_IDX_W;
  localparam int unsigned CW = r565y420_pkg::CHROMA_W;
  localparam int unsigned QW = CW - r565y420_pkg::CHROMA_SHIFT;

  // luma index of one pixel, saturated to the last table entry
  function automatic r565y420_pkg::luma_idx_t luma_index(
    input logic [r565y420_pkg::PIXEL_W-1:0] px
  );
    logic [r565y420_pkg::LUMA_MIX_W-1:0] mix;
    logic [IW-1:0]                       raw;
    mix = r565y420_pkg::LUMA_MIX_W'(r565y420_pkg::LUMA_BLUE_GAIN) *
          r565y420_pkg::LUMA_MIX_W'(px[4:0]) +
          r565y420_pkg::LUMA_MIX_W'(r565y420_pkg::LUMA_RED_GAIN) *
          r565y420_pkg::LUMA_MIX_W'(px[15:11]);
    raw = IW'(mix >> r565y420_pkg::LUMA_MIX_SHIFT) + IW'({px[10:5], 2'b00});
    if (int'(raw) > int'(LUMA_ROM_DEPTH) - 1) begin
      raw = IW'(LUMA_ROM_DEPTH - 1);
    end
    return raw;
  endfunction

  // clamp a shifted chroma sum into the table's signed index range
  function automatic r565y420_pkg::diff_idx_t diff_sat(input logic signed [QW-1:0] q);
    if (q < -QW'(r565y420_pkg::DIFF_OFFSET)) begin
      return -r565y420_pkg::DIFF_IDX_W'(r565y420_pkg::DIFF_OFFSET);
    end
    if (q > QW'(r565y420_pkg::DIFF_OFFSET - 1)) begin
      return r565y420_pkg::DIFF_IDX_W'(r565y420_pkg::DIFF_OFFSET - 1);
    end
    return r565y420_pkg::DIFF_IDX_W'(q);
  endfunction

  // pair channel sums, scaled by 16
  logic [r565y420_pkg::COMP_W:0] red_sum, green_sum, blue_sum;
  logic signed [CW-1:0]          red_s, green_s, blue_s, cross_s;
  logic signed [CW-1:0]          cb_num, cr_num;
  logic signed [QW-1:0]          cb_q, cr_q;

  always_comb begin
    red_sum   = (r565y420_pkg::COMP_W+1)'(in_pair.pixel_first[15:11]) +
                (r565y420_pkg::COMP_W+1)'(in_pair.pixel_second[15:11]);
    green_sum = (r565y420_pkg::COMP_W+1)'(in_pair.pixel_first[10:6]) +
                (r565y420_pkg::COMP_W+1)'(in_pair.pixel_second[10:6]);
    blue_sum  = (r565y420_pkg::COMP_W+1)'(in_pair.pixel_first[4:0]) +
                (r565y420_pkg::COMP_W+1)'(in_pair.pixel_second[4:0]);
    red_s     = CW'($signed({1'b0, red_sum, 4'b0000}));
    green_s   = CW'($signed({1'b0, green_sum, 4'b0000}));
    blue_s    = CW'($signed({1'b0, blue_sum, 4'b0000}));
    cross_s   = red_s - blue_s;
    cb_num    = ((blue_s - green_s) <<< r565y420_pkg::CHROMA_G_SHIFT) -
                CW'(r565y420_pkg::CB_CROSS_GAIN) * cross_s;
    cr_num    = ((red_s - green_s) <<< r565y420_pkg::CHROMA_G_SHIFT) +
                CW'(r565y420_pkg::CR_CROSS_GAIN) * cross_s;
    cb_q      = QW'(cb_num >>> r565y420_pkg::CHROMA_SHIFT);
    cr_q      = QW'(cr_num >>> r565y420_pkg::CHROMA_SHIFT);
  end

  // pipeline handshake
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic s2_adv, in_take;

  assign s2_adv        = !out_valid_r || out_yuv.ready;
  assign in_pair.ready = rst_n && (!s1_valid_r || s2_adv);
  assign in_take       = in_pair.valid && in_pair.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s2_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s2_adv) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // stage one: table indices
  r565y420_pkg::luma_idx_t luma_idx_first_r, luma_idx_second_r;
  r565y420_pkg::diff_idx_t cb_idx_r, cr_idx_r;
  logic                    keep_s1_r;

  always_ff @(posedge clk) begin
    if (in_take) begin
      luma_idx_first_r  <= luma_index(in_pair.pixel_first);
      luma_idx_second_r <= luma_index(in_pair.pixel_second);
      cb_idx_r          <= diff_sat(cb_q);
      cr_idx_r          <= diff_sat(cr_q);
      keep_s1_r         <= in_pair.even_row;
    end
  end

  // stage two: curve values into the output register
  r565y420_pkg::chan_t luma_first_r, luma_second_r, chroma_blue_r, chroma_red_r;
  logic                chroma_keep_r;

  always_ff @(posedge clk) begin
    if (s2_adv && s1_valid_r) begin
      luma_first_r  <= r565y420_pkg::luma_value(luma_idx_first_r);
      luma_second_r <= r565y420_pkg::luma_value(luma_idx_second_r);
      chroma_blue_r <= r565y420_pkg::diff_value(cb_idx_r, r565y420_pkg::CB_GAIN);
      chroma_red_r  <= r565y420_pkg::diff_value(cr_idx_r, r565y420_pkg::CR_GAIN);
      chroma_keep_r <= keep_s1_r;
    end
  end

  assign out_yuv.valid       = out_valid_r;
  assign out_yuv.luma_first  = luma_first_r;
  assign out_yuv.luma_second = luma_second_r;
  assign out_yuv.chroma_blue = chroma_blue_r;
  assign out_yuv.chroma_red  = chroma_red_r;
  assign out_yuv.chroma_keep = chroma_keep_r;

endmodule

`default_nettype wire

// ===== rtl/r565y420_chk.sv =====
// port-level checker for the rgb565 pair to yuv420 converter, bound to the top level
// depends on r565y420_pkg and rgb565_pair_to_yuv420
`default_nettype none

module r565y420_chk (
  input wire                      clk,
  input wire                      rst_n,
  input wire                      in_ready,
  input wire                      out_valid,
  input wire                      out_ready,
  input wire [7:0]                luma_first,
  input wire [7:0]                luma_second,
  input wire [7:0]                chroma_blue,
  input wire [7:0]                chroma_red,
  input wire                      chroma_keep
);

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // luma stays inside the limited range
  a_luma_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (luma_first >= 8'(r565y420_pkg::LUMA_LO)) &&
                  (luma_first <= 8'(r565y420_pkg::LUMA_HI)) &&
                  (luma_second >= 8'(r565y420_pkg::LUMA_LO)) &&
                  (luma_second <= 8'(r565y420_pkg::LUMA_HI)))
    else $error("luma out of range");

  // an empty output register never blocks a request
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(luma_first) && $stable(luma_second) &&
                                $stable(chroma_blue) && $stable(chroma_red) &&
                                $stable(chroma_keep))
    else $error("stalled result changed");

endmodule

bind rgb565_pair_to_yuv420 r565y420_chk u_r565y420_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_pair.ready),
  .out_valid   (out_yuv.valid),
  .out_ready   (out_yuv.ready),
  .luma_first  (out_yuv.luma_first),
  .luma_second (out_yuv.luma_second),
  .chroma_blue (out_yuv.chroma_blue),
  .chroma_red  (out_yuv.chroma_red),
  .chroma_keep (out_yuv.chroma_keep)
);

`default_nettype wire
